[rtl/core/wck_pkg.sv]
package wck_pkg;

    localparam int ANGLE_BITS_DEF   = 16;
    localparam int VALUE_BITS_DEF   = 18;
    localparam int CORDIC_STEPS_DEF = 16;

    // Angles inside the rotator are kept in turns scaled by 2^TURN_BITS
    localparam int TURN_BITS    = 32;
    localparam int ATAN_ENTRIES = 24;
    localparam int ATAN_BITS    = 30;

    // Reciprocal of the rotator gain, Q30
    localparam int                   KINV_BITS = 30;
    localparam logic [KINV_BITS-1:0] KINV_Q30  = 30'd652032874;

    localparam int KINV_SHIFT = 14;
    localparam int POS_SHIFT  = 16;
    localparam int VEL_SHIFT  = 14;

    function automatic logic [ATAN_BITS-1:0] atan_q32(input int unsigned idx);
        logic [ATAN_BITS-1:0] val;
        case (idx)
            0:       val = 30'd536870912;
            1:       val = 30'd316933406;
            2:       val = 30'd167458907;
            3:       val = 30'd85004756;
            4:       val = 30'd42667331;
            5:       val = 30'd21354465;
            6:       val = 30'd10679838;
            7:       val = 30'd5340245;
            8:       val = 30'd2670163;
            9:       val = 30'd1335087;
            10:      val = 30'd667544;
            11:      val = 30'd333772;
            12:      val = 30'd166886;
            13:      val = 30'd83443;
            14:      val = 30'd41722;
            15:      val = 30'd20861;
            16:      val = 30'd10430;
            17:      val = 30'd5215;
            18:      val = 30'd2608;
            19:      val = 30'd1304;
            20:      val = 30'd652;
            21:      val = 30'd326;
            22:      val = 30'd163;
            23:      val = 30'd81;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

[rtl/core/wck_req_if.sv]
interface wck_req_if
    import wck_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [ANGLE_BITS-1:0] steer_angle;
    logic signed [VALUE_BITS-1:0] wheel_offset_x;
    logic signed [VALUE_BITS-1:0] wheel_offset_y;
    logic signed [VALUE_BITS-1:0] caster_offset_x;
    logic signed [VALUE_BITS-1:0] caster_offset_y;
    logic signed [VALUE_BITS-1:0] base_vel_x;
    logic signed [VALUE_BITS-1:0] base_vel_y;
    logic signed [VALUE_BITS-1:0] base_yaw_rate;

    modport source
    (
        output valid, steer_angle, wheel_offset_x, wheel_offset_y,
               caster_offset_x, caster_offset_y, base_vel_x, base_vel_y, base_yaw_rate,
        input  ready
    );

    modport sink
    (
        input  valid, steer_angle, wheel_offset_x, wheel_offset_y,
               caster_offset_x, caster_offset_y, base_vel_x, base_vel_y, base_yaw_rate,
        output ready
    );
endinterface

[rtl/core/wck_rsp_if.sv]
interface wck_rsp_if
    import wck_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] wheel_pos_x;
    logic signed [VALUE_BITS-1:0] wheel_pos_y;
    logic signed [VALUE_BITS-1:0] wheel_vel_x;
    logic signed [VALUE_BITS-1:0] wheel_vel_y;
    logic                         saturated;

    modport source
    (
        output valid, wheel_pos_x, wheel_pos_y, wheel_vel_x, wheel_vel_y, saturated,
        input  ready
    );

    modport sink
    (
        input  valid, wheel_pos_x, wheel_pos_y, wheel_vel_x, wheel_vel_y, saturated,
        output ready
    );
endinterface

[rtl/core/wheel_contact_kinematics.sv]
// Caster wheel position and contact point velocity.
// A request on req carries the steering angle, the wheel offset from the
// caster pivot, the pivot offset from the base centre and the base twist.
// Each request gives exactly one response on rsp: the wheel position in the
// base frame and the planar velocity of that point, both saturated, with a
// flag that is set when any field was clipped.
// Both channels move an item at a clock edge where valid and ready are high.
// The pipeline registers are, in order: one for the gain-correcting
// multiply, one for the quadrant fold, one per rotator stage, one for the
// position add, one for the yaw-rate multiply and one for the velocity add
// into the output register.
// One request per cycle is taken unless rsp stalls; every stage is a register.
// When rsp stalls with a response waiting, the whole pipeline holds and
// req.ready drops in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits at once; the block takes requests from the
// first clock edge after reset is released.
module wheel_contact_kinematics
    import wck_pkg::*;
#(
    parameter int ANGLE_BITS   = ANGLE_BITS_DEF,
    parameter int VALUE_BITS   = VALUE_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    wck_req_if.sink   req,
    wck_rsp_if.source rsp
);

    localparam int STEPS  = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
    localparam int VB     = VALUE_BITS;
    localparam int XW     = VB + 18;
    localparam int ZW     = TURN_BITS + 2;
    localparam int PW     = VB + KINV_BITS + 1;
    localparam int SW     = XW + 1;
    localparam int MW     = 2 * VB;
    localparam int VW     = MW + 2;
    localparam int SIDE_W = 5 * VB;
    localparam int LAT    = STEPS + 5;
    localparam int S_POS  = STEPS + 2;

    localparam logic signed [KINV_BITS:0] KINV_S    = $signed({1'b0, KINV_Q30});
    localparam logic signed [ZW-1:0]      Z_QUARTER = ZW'(1) << (TURN_BITS - 2);
    localparam logic signed [ZW-1:0]      Z_HALF    = ZW'(1) << (TURN_BITS - 1);
    localparam logic signed [XW-1:0]      X_ROUND   = XW'(1) << (POS_SHIFT - 1);
    localparam logic signed [VW-1:0]      V_ROUND   = VW'(1) << (VEL_SHIFT - 1);
    localparam logic [VB-1:0]             V_MAX     = {1'b0, {(VB-1){1'b1}}};
    localparam logic [VB-1:0]             V_MIN     = ~V_MAX;

    function automatic logic [VB:0] clip_pos(input logic signed [SW-1:0] v);
        logic fits;
        fits = (v == SW'($signed(v[VB-1:0])));
        return fits ? {1'b0, v[VB-1:0]} : {1'b1, (v[SW-1] ? V_MIN : V_MAX)};
    endfunction

    function automatic logic [VB:0] clip_vel(input logic signed [VW-1:0] v);
        logic fits;
        fits = (v == VW'($signed(v[VB-1:0])));
        return fits ? {1'b0, v[VB-1:0]} : {1'b1, (v[VW-1] ? V_MIN : V_MAX)};
    endfunction

    logic [LAT-1:0] valid_reg;
    logic           adv;

    assign adv       = !valid_reg[LAT-1] || rsp.ready;
    assign req.ready = adv;
    assign rsp.valid = valid_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[LAT-2:0], req.valid};
        end
    end

    logic [SIDE_W-1:0] side_reg [0:S_POS];

    // gain correction and quadrant detection
    logic signed [PW-1:0]     prodx_next, prody_next;
    logic signed [PW-1:0]     prodx_reg,  prody_reg;
    logic signed [ZW-1:0]     z_in, z0_next, z0_reg;
    logic                     fold0_next, fold0_reg;
    logic [SIDE_W-1:0]        side_next;

    always_comb
    begin
        prodx_next = req.wheel_offset_x * KINV_S;
        prody_next = req.wheel_offset_y * KINV_S;
        z_in       = ZW'(req.steer_angle) <<< (TURN_BITS - ANGLE_BITS);
        if (z_in > Z_QUARTER)
        begin
            fold0_next = 1'b1;
            z0_next    = z_in - Z_HALF;
        end
        else if (z_in < -Z_QUARTER)
        begin
            fold0_next = 1'b1;
            z0_next    = z_in + Z_HALF;
        end
        else
        begin
            fold0_next = 1'b0;
            z0_next    = z_in;
        end
        side_next = {req.caster_offset_x, req.caster_offset_y,
                     req.base_vel_x, req.base_vel_y, req.base_yaw_rate};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prodx_reg   <= prodx_next;
            prody_reg   <= prody_next;
            z0_reg      <= z0_next;
            fold0_reg   <= fold0_next;
            side_reg[0] <= side_next;
        end
    end

    // rotator input: scale down and fold by a half turn
    logic signed [XW-1:0] x_reg [0:STEPS];
    logic signed [XW-1:0] y_reg [0:STEPS];
    logic signed [ZW-1:0] z_reg [0:STEPS];
    logic signed [XW-1:0] xs_next, ys_next;

    always_comb
    begin
        xs_next = XW'(prodx_reg >>> KINV_SHIFT);
        ys_next = XW'(prody_reg >>> KINV_SHIFT);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg[0]    <= fold0_reg ? -xs_next : xs_next;
            y_reg[0]    <= fold0_reg ? -ys_next : ys_next;
            z_reg[0]    <= z0_reg;
            side_reg[1] <= side_reg[0];
        end
    end

    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        logic signed [XW-1:0] dx, dy, x_next, y_next;
        logic signed [ZW-1:0] at, z_next;

        always_comb
        begin
            dx = x_reg[k] >>> k;
            dy = y_reg[k] >>> k;
            at = $signed({{(ZW-ATAN_BITS){1'b0}}, atan_q32(k)});
            if (!z_reg[k][ZW-1])
            begin
                x_next = x_reg[k] - dy;
                y_next = y_reg[k] + dx;
                z_next = z_reg[k] - at;
            end
            else
            begin
                x_next = x_reg[k] + dy;
                y_next = y_reg[k] - dx;
                z_next = z_reg[k] + at;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                x_reg[k+1]    <= x_next;
                y_reg[k+1]    <= y_next;
                z_reg[k+1]    <= z_next;
                side_reg[k+2] <= side_reg[k+1];
            end
        end
    end

    // wheel position
    logic signed [XW-1:0] xr, yr;
    logic [VB:0]          posx_next, posy_next;
    logic signed [VB-1:0] px_reg, py_reg;
    logic                 satp_reg;

    always_comb
    begin
        xr        = (x_reg[STEPS] + X_ROUND) >>> POS_SHIFT;
        yr        = (y_reg[STEPS] + X_ROUND) >>> POS_SHIFT;
        posx_next = clip_pos(SW'(xr) + SW'($signed(side_reg[STEPS+1][5*VB-1 -: VB])));
        posy_next = clip_pos(SW'(yr) + SW'($signed(side_reg[STEPS+1][4*VB-1 -: VB])));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px_reg          <= $signed(posx_next[VB-1:0]);
            py_reg          <= $signed(posy_next[VB-1:0]);
            satp_reg        <= posx_next[VB] | posy_next[VB];
            side_reg[S_POS] <= side_reg[STEPS+1];
        end
    end

    // yaw-rate products
    logic signed [VB-1:0] wz;
    logic signed [MW-1:0] mulx_next, muly_next, mulx_reg, muly_reg;
    logic signed [VB-1:0] px_m_reg, py_m_reg, vx_m_reg, vy_m_reg;
    logic                 satm_reg;

    always_comb
    begin
        wz        = $signed(side_reg[S_POS][VB-1:0]);
        mulx_next = py_reg * wz;
        muly_next = px_reg * wz;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mulx_reg <= mulx_next;
            muly_reg <= muly_next;
            px_m_reg <= px_reg;
            py_m_reg <= py_reg;
            vx_m_reg <= $signed(side_reg[S_POS][3*VB-1 -: VB]);
            vy_m_reg <= $signed(side_reg[S_POS][2*VB-1 -: VB]);
            satm_reg <= satp_reg;
        end
    end

    // contact point velocity
    logic signed [VW-1:0] rx, ry;
    logic [VB:0]          velx_next, vely_next;
    logic signed [VB-1:0] pos_x_out_reg, pos_y_out_reg, vel_x_out_reg, vel_y_out_reg;
    logic                 sat_out_reg;

    always_comb
    begin
        rx        = (VW'(mulx_reg) + V_ROUND) >>> VEL_SHIFT;
        ry        = (VW'(muly_reg) + V_ROUND) >>> VEL_SHIFT;
        velx_next = clip_vel(VW'(vx_m_reg) - rx);
        vely_next = clip_vel(VW'(vy_m_reg) + ry);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pos_x_out_reg <= px_m_reg;
            pos_y_out_reg <= py_m_reg;
            vel_x_out_reg <= $signed(velx_next[VB-1:0]);
            vel_y_out_reg <= $signed(vely_next[VB-1:0]);
            sat_out_reg   <= satm_reg | velx_next[VB] | vely_next[VB];
        end
    end

    assign rsp.wheel_pos_x = pos_x_out_reg;
    assign rsp.wheel_pos_y = pos_y_out_reg;
    assign rsp.wheel_vel_x = vel_x_out_reg;
    assign rsp.wheel_vel_y = vel_y_out_reg;
    assign rsp.saturated   = sat_out_reg;

endmodule

[rtl/core/wck_checker.sv]
module wck_checker
#(
    parameter int DATA_W = 73
)
(
    input logic              clk,
    input logic              rst_n,
    input logic              req_ready,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input logic [DATA_W-1:0] rsp_data
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_data))
        else $error("response changed while stalled");

    a_req_ready: assert property (@(posedge clk) disable iff (!rst_n)
        req_ready == (!rsp_valid || rsp_ready))
        else $error("request ready does not follow output stall");

    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !rsp_valid)
        else $error("response valid straight after reset");

endmodule

bind wheel_contact_kinematics wck_checker
#(
    .DATA_W(4 * VALUE_BITS + 1)
)
u_wck_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  ({rsp.wheel_pos_x, rsp.wheel_pos_y, rsp.wheel_vel_x,
                 rsp.wheel_vel_y, rsp.saturated})
);
